// ===== rtl/ias_pkg.sv =====
package ias_pkg;

	localparam int WordW = 40;
	localparam int AddrW = 12;
	localparam int OpcW  = 8;
	localparam int FieldW = 12;
	localparam int LeftFieldLo = 20;

	typedef logic [WordW-1:0] word_t;

	localparam logic [OpcW-1:0] OPC_LOAD       = 8'd1;
	localparam logic [OpcW-1:0] OPC_LOAD_NEG   = 8'd2;
	localparam logic [OpcW-1:0] OPC_LOAD_ABS   = 8'd3;
	localparam logic [OpcW-1:0] OPC_LOAD_NABS  = 8'd4;
	localparam logic [OpcW-1:0] OPC_ADD        = 8'd5;
	localparam logic [OpcW-1:0] OPC_SUB        = 8'd6;
	localparam logic [OpcW-1:0] OPC_ADD_ABS    = 8'd7;
	localparam logic [OpcW-1:0] OPC_SUB_ABS    = 8'd8;
	localparam logic [OpcW-1:0] OPC_LOAD_MQ_M  = 8'd9;
	localparam logic [OpcW-1:0] OPC_LOAD_MQ    = 8'd10;
	localparam logic [OpcW-1:0] OPC_MUL        = 8'd11;
	localparam logic [OpcW-1:0] OPC_DIV        = 8'd12;
	localparam logic [OpcW-1:0] OPC_JUMP_L     = 8'd13;
	localparam logic [OpcW-1:0] OPC_JUMP_R     = 8'd14;
	localparam logic [OpcW-1:0] OPC_JUMPP_L    = 8'd15;
	localparam logic [OpcW-1:0] OPC_JUMPP_R    = 8'd16;
	localparam logic [OpcW-1:0] OPC_STOR_L     = 8'd18;
	localparam logic [OpcW-1:0] OPC_STOR_R     = 8'd19;
	localparam logic [OpcW-1:0] OPC_LSH        = 8'd20;
	localparam logic [OpcW-1:0] OPC_RSH        = 8'd21;
	localparam logic [OpcW-1:0] OPC_STOR       = 8'd33;

	function automatic word_t neg_w(input word_t v);
		return ~v + word_t'(1);
	endfunction

	function automatic word_t mag_w(input word_t v);
		return v[WordW-1] ? neg_w(v) : v;
	endfunction

endpackage

// ===== rtl/ias_instruction_execute_unit.sv =====
// IAS execute unit: one word in, one result word out. A memory write goes
// through the address register and then the result register; other
// instructions go through the operand read from the synchronous word memory,
// execute and the result register. Multiply and divide run one bit per cycle
// in a shared shift-add/subtract loop before the result register. The next
// word is accepted only after the result handshake and the return to idle.
// After reset the memory is cleared one entry a cycle, during which no word is
// accepted. One item at a time.
module ias_instruction_execute_unit #(
	parameter int MEM_DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     op,
	input  logic [7:0]               opcode,
	input  logic [11:0]              address,
	input  logic [39:0]              data_word,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [39:0]              acc_value,
	output logic [39:0]              mq_value,
	output logic                     jump_taken,
	output logic [11:0]              jump_target,
	output logic                     jump_right_half,
	output logic                     store_valid,
	output logic [11:0]              store_address,
	output logic [39:0]              store_data,
	output logic                     divide_fault
);
	import ias_pkg::*;

	localparam int MemAw = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int CntW  = $clog2(WordW + 1);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_ITER, ST_OUT
	} state_t;

	state_t state_q;
	word_t mem [MEM_DEPTH];
	word_t rd_data_q;
	logic [MemAw:0] clr_q;

	logic             op_q;
	logic [OpcW-1:0]  opc_q;
	logic [AddrW-1:0] addr_q;
	word_t            data_q;
	logic             in_range_q;

	word_t ac_q, mq_q;
	// iteration registers: multiply uses p_q:b_q, divide uses rem_q:b_q
	word_t p_q, b_q, m_q;
	logic [WordW:0] rem_q;
	logic [CntW-1:0] cnt_q;
	logic neg_res_q;

	logic wr_en;
	logic [MemAw-1:0] wr_addr;
	word_t wr_data;

	logic [WordW:0] add_sum;
	logic [WordW:0] rem_sh;
	logic [WordW:0] rem_sub;
	word_t m_mag, ac_mag, m_op;

	assign in_ready  = (state_q == ST_IDLE);
	assign m_op      = in_range_q ? rd_data_q : '0;
	assign m_mag     = mag_w(m_op);
	assign ac_mag    = mag_w(ac_q);
	assign add_sum   = {1'b0, p_q} + (b_q[0] ? {1'b0, m_q} : '0);
	assign rem_sh    = {rem_q[WordW-1:0], b_q[WordW-1]};
	assign rem_sub   = rem_sh - {1'b0, m_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[addr_q[MemAw-1:0]];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q[MemAw-1:0];
		wr_data = data_q;
		if (state_q == ST_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q[MemAw-1:0];
			wr_data = '0;
		end else if (state_q == ST_READ) begin
			wr_en = !op_q && in_range_q;
		end else if (state_q == ST_EXEC && op_q && in_range_q) begin
			unique case (opc_q)
				OPC_STOR: begin
					wr_en = 1'b1; wr_data = ac_q;
				end
				OPC_STOR_L: begin
					wr_en = 1'b1;
					wr_data = m_op;
					wr_data[LeftFieldLo +: FieldW] = ac_q[FieldW-1:0];
				end
				OPC_STOR_R: begin
					wr_en = 1'b1;
					wr_data = m_op;
					wr_data[FieldW-1:0] = ac_q[FieldW-1:0];
				end
				default: wr_en = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			ac_q      <= '0;
			mq_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (MemAw+1)'(MEM_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q       <= op;
						opc_q      <= opcode;
						addr_q     <= address;
						data_q     <= data_word;
						in_range_q <= ({1'b0, address} < (AddrW+1)'(MEM_DEPTH));
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					jump_taken      <= 1'b0;
					jump_target     <= '0;
					jump_right_half <= 1'b0;
					store_valid     <= 1'b0;
					store_address   <= '0;
					store_data      <= '0;
					divide_fault    <= 1'b0;
					state_q <= op_q ? ST_EXEC : ST_OUT;
				end
				ST_EXEC: begin
					if (opc_q == OPC_MUL || (opc_q == OPC_DIV && m_op != '0)) begin
						state_q <= ST_ITER;
					end else begin
						state_q <= ST_OUT;
					end
					unique case (opc_q)
						OPC_LOAD:      ac_q <= m_op;
						OPC_LOAD_NEG:  ac_q <= neg_w(m_op);
						OPC_LOAD_ABS:  ac_q <= m_mag;
						OPC_LOAD_NABS: ac_q <= neg_w(m_mag);
						OPC_ADD:       ac_q <= ac_q + m_op;
						OPC_SUB:       ac_q <= ac_q + neg_w(m_op);
						OPC_ADD_ABS:   ac_q <= ac_q + m_mag;
						OPC_SUB_ABS:   ac_q <= ac_q + neg_w(m_mag);
						OPC_LOAD_MQ_M: mq_q <= m_op;
						OPC_LOAD_MQ:   ac_q <= mq_q;
						OPC_MUL: begin
							p_q <= '0;
							b_q <= mag_w(mq_q);
							m_q <= m_mag;
							neg_res_q <= mq_q[WordW-1] ^ m_op[WordW-1];
							cnt_q <= '0;
						end
						OPC_DIV: begin
							if (m_op == '0) begin
								divide_fault <= 1'b1;
							end else begin
								rem_q <= '0;
								b_q <= ac_mag;
								m_q <= m_mag;
								neg_res_q <= ac_q[WordW-1] ^ m_op[WordW-1];
								cnt_q <= '0;
							end
						end
						OPC_JUMP_L, OPC_JUMP_R: begin
							jump_taken      <= 1'b1;
							jump_target     <= addr_q;
							jump_right_half <= (opc_q == OPC_JUMP_R);
						end
						OPC_JUMPP_L, OPC_JUMPP_R: begin
							if (!ac_q[WordW-1]) begin
								jump_taken      <= 1'b1;
								jump_target     <= addr_q;
								jump_right_half <= (opc_q == OPC_JUMPP_R);
							end
						end
						OPC_LSH: ac_q <= {ac_q[WordW-2:0], 1'b0};
						OPC_RSH: ac_q <= {ac_q[WordW-1], ac_q[WordW-1:1]};
						OPC_STOR, OPC_STOR_L, OPC_STOR_R: begin
							if (in_range_q) begin
								store_valid   <= 1'b1;
								store_address <= addr_q;
								store_data    <= wr_data;
							end
						end
						default: ;
					endcase
				end
				ST_ITER: begin
					if (cnt_q == CntW'(WordW)) begin
						state_q <= ST_OUT;
						if (opc_q == OPC_MUL) begin
							if (neg_res_q) begin
								mq_q <= neg_w(b_q);
								ac_q <= ~p_q + ((b_q == '0) ? word_t'(1) : '0);
							end else begin
								mq_q <= b_q;
								ac_q <= p_q;
							end
						end else begin
							mq_q <= neg_res_q ? neg_w(b_q) : b_q;
							ac_q <= rem_q[WordW-1:0];
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (opc_q == OPC_MUL) begin
							// shift product right, multiplier bits leave b_q
							p_q <= add_sum[WordW:1];
							b_q <= {add_sum[0], b_q[WordW-1:1]};
						end else begin
							// restoring division, one quotient bit a cycle
							if (!rem_sub[WordW]) begin
								rem_q <= rem_sub;
								b_q   <= {b_q[WordW-2:0], 1'b1};
							end else begin
								rem_q <= rem_sh;
								b_q   <= {b_q[WordW-2:0], 1'b0};
							end
						end
					end
				end
				ST_OUT: begin
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end else begin
						out_valid <= 1'b1;
						acc_value <= ac_q;
						mq_value  <= mq_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("word accepted while result pending");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("accept during memory clear");
	a_store_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && store_valid) |-> (store_address == addr_q))
		else $error("store address mismatch");
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ITER) |-> (cnt_q <= CntW'(WordW)))
		else $error("iteration count overrun");
endmodule

// ===== tb/ias_execute_checker.sv =====
module ias_execute_checker
	import ias_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        op,
	input  logic [7:0]  opcode,
	input  logic [11:0] address,
	input  logic [39:0] data_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [39:0] acc_value,
	input  logic [39:0] mq_value,
	input  logic        jump_taken,
	input  logic [11:0] jump_target,
	input  logic        jump_right_half,
	input  logic        store_valid,
	input  logic [11:0] store_address,
	input  logic [39:0] store_data,
	input  logic        divide_fault,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [39:0] acc;
		logic [39:0] mq;
		logic        jt;
		logic [11:0] jtar;
		logic        jr;
		logic        sv;
		logic [11:0] sa;
		logic [39:0] sd;
		logic        df;
	} exec_result_t;

	exec_result_t result_q[$];
	logic [39:0] model_ac, model_mq;
	logic [39:0] model_mem [0:4095];

	function automatic logic [39:0] negate(input logic [39:0] v);
		return ~v + 40'd1;
	endfunction

	function automatic logic [39:0] magnitude(input logic [39:0] v);
		return v[39] ? negate(v) : v;
	endfunction

	task automatic execute_word(input logic o, input logic [7:0] opc,
			input logic [11:0] a, input logic [39:0] d);
		exec_result_t r;
		logic [39:0] m, nw, ma, mb;
		logic [79:0] prod;
		logic st;
		r = '0;
		m = model_mem[a];
		nw = '0;
		st = 1'b0;
		if (!o) begin
			model_mem[a] = d;
		end else begin
			case (opc)
				OPC_LOAD:      model_ac = m;
				OPC_LOAD_NEG:  model_ac = negate(m);
				OPC_LOAD_ABS:  model_ac = magnitude(m);
				OPC_LOAD_NABS: model_ac = negate(magnitude(m));
				OPC_ADD:       model_ac = model_ac + m;
				OPC_SUB:       model_ac = model_ac + negate(m);
				OPC_ADD_ABS:   model_ac = model_ac + magnitude(m);
				OPC_SUB_ABS:   model_ac = model_ac + negate(magnitude(m));
				OPC_LOAD_MQ_M: model_mq = m;
				OPC_LOAD_MQ:   model_ac = model_mq;
				OPC_MUL: begin
					prod = {40'd0, magnitude(model_mq)} * {40'd0, magnitude(m)};
					if (model_mq[39] != m[39]) prod = ~prod + 80'd1;
					model_ac = prod[79:40];
					model_mq = prod[39:0];
				end
				OPC_DIV: begin
					if (m == '0) begin
						r.df = 1'b1;
					end else begin
						ma = magnitude(model_ac);
						mb = magnitude(m);
						model_mq = (model_ac[39] != m[39]) ? negate(ma / mb) : ma / mb;
						model_ac = ma % mb;
					end
				end
				OPC_JUMP_L, OPC_JUMP_R: begin
					r.jt = 1'b1;
					r.jtar = a;
					r.jr = (opc == OPC_JUMP_R);
				end
				OPC_JUMPP_L, OPC_JUMPP_R: begin
					if (!model_ac[39]) begin
						r.jt = 1'b1;
						r.jtar = a;
						r.jr = (opc == OPC_JUMPP_R);
					end
				end
				OPC_LSH: model_ac = model_ac << 1;
				OPC_RSH: model_ac = {model_ac[39], model_ac[39:1]};
				OPC_STOR: begin
					nw = model_ac;
					st = 1'b1;
				end
				OPC_STOR_L: begin
					nw = m;
					nw[31:20] = model_ac[11:0];
					st = 1'b1;
				end
				OPC_STOR_R: begin
					nw = {m[39:12], model_ac[11:0]};
					st = 1'b1;
				end
				default: ;
			endcase
			if (st) begin
				model_mem[a] = nw;
				r.sv = 1'b1;
				r.sa = a;
				r.sd = nw;
			end
		end
		r.acc = model_ac;
		r.mq = model_mq;
		result_q.push_back(r);
	endtask

	assign pending = result_q.size();

	always @(posedge clk or negedge arst_n) begin
		exec_result_t e, got;
		if (!arst_n) begin
			model_ac <= '0;
			model_mq <= '0;
			for (int i = 0; i < 4096; i++) model_mem[i] = '0;
			result_q.delete();
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready) execute_word(op, opcode, address, data_word);
			if (out_valid && out_ready) begin
				got = '{acc_value, mq_value, jump_taken, jump_target, jump_right_half,
					store_valid, store_address, store_data, divide_fault};
				if (result_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected result word %h", got);
					fail_count <= fail_count + 1;
				end else begin
					e = result_q.pop_front();
					if (got !== e) begin
						if (fail_count < 10) begin
							$display("mismatch acc exp %h got %h mq exp %h got %h",
								e.acc, got.acc, e.mq, got.mq);
							$display("  jump exp %b/%h/%b got %b/%h/%b", e.jt, e.jtar, e.jr,
								got.jt, got.jtar, got.jr);
							$display("  store exp %b/%h/%h got %b/%h/%h fault exp %b got %b",
								e.sv, e.sa, e.sd, got.sv, got.sa, got.sd, e.df, got.df);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== tb/ias_instruction_execute_unit_tb.sv =====
module ias_instruction_execute_unit_tb;
	import ias_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomWords = 1930;
	localparam int CycleLimit  = 900000;

	logic clk, arst_n;
	logic in_valid, in_ready, op;
	logic [7:0] opcode;
	logic [11:0] address;
	logic [39:0] data_word;
	logic out_valid, out_ready;
	logic [39:0] acc_value, mq_value, store_data;
	logic jump_taken, jump_right_half, store_valid, divide_fault;
	logic [11:0] jump_target, store_address;
	int fail_count, pending, cycle_count;

	ias_instruction_execute_unit u_dut (.*);

	ias_execute_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: hold ready low for a random stretch after most words
	initial begin
		int gap;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
				if (gap != 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				out_ready <= 1'b1;
			end else if (!out_ready) begin
				out_ready <= 1'b1;
			end
		end
	end

	// valid stays high into the next word when there is no gap
	task automatic send_word(input logic o, input logic [7:0] opc,
			input logic [11:0] a, input logic [39:0] d, input int gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		opcode <= opc;
		address <= a;
		data_word <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [39:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 40'h80_0000_0000;
			1: return 40'h7F_FFFF_FFFF;
			2: return '0;
			3: return {40{1'b1}};
			4: return 40'($urandom_range(0, 40));
			default: return {8'($urandom), $urandom};
		endcase
	endfunction

	function automatic logic [7:0] pick_opcode();
		logic [7:0] valid_ops [21] = '{OPC_LOAD, OPC_LOAD_NEG, OPC_LOAD_ABS,
			OPC_LOAD_NABS, OPC_ADD, OPC_SUB, OPC_ADD_ABS, OPC_SUB_ABS, OPC_LOAD_MQ_M,
			OPC_LOAD_MQ, OPC_MUL, OPC_DIV, OPC_JUMP_L, OPC_JUMP_R, OPC_JUMPP_L,
			OPC_JUMPP_R, OPC_STOR_L, OPC_STOR_R, OPC_LSH, OPC_RSH, OPC_STOR};
		if ($urandom_range(0, 15) == 0) return 8'($urandom);
		return valid_ops[$urandom_range(0, 20)];
	endfunction

	initial begin
		int gap;
		logic [11:0] a;
		in_valid = 1'b0;
		op = 1'b0;
		opcode = '0;
		address = '0;
		data_word = '0;
		cycle_count = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extreme operands through most operations
		send_word(1'b0, 8'd0, 12'd0, 40'h80_0000_0000, 0);
		send_word(1'b0, 8'hFF, 12'hFFF, 40'h7F_FFFF_FFFF, 0);
		send_word(1'b0, 8'd0, 12'd1, 40'd0, 0);
		send_word(1'b1, OPC_LOAD_ABS, 12'd0, '0, 0);
		send_word(1'b1, OPC_LOAD_NEG, 12'd0, '0, 0);
		send_word(1'b1, OPC_LOAD_MQ_M, 12'd0, '0, 0);
		send_word(1'b1, OPC_MUL, 12'd0, '0, 0);
		send_word(1'b1, OPC_LOAD, 12'hFFF, '0, 0);
		send_word(1'b1, OPC_ADD, 12'hFFF, '0, 0);
		send_word(1'b1, OPC_SUB_ABS, 12'd0, '0, 0);
		send_word(1'b1, OPC_DIV, 12'd1, '0, 0);
		send_word(1'b1, OPC_DIV, 12'd0, '0, 0);
		send_word(1'b1, OPC_JUMPP_R, 12'hABC, '0, 0);
		send_word(1'b1, OPC_LOAD_NABS, 12'hFFF, '0, 0);
		send_word(1'b1, OPC_JUMPP_L, 12'h555, '0, 0);
		send_word(1'b1, OPC_JUMP_R, 12'hFFF, '0, 0);
		send_word(1'b1, OPC_RSH, 12'd0, '0, 0);
		send_word(1'b1, OPC_LSH, 12'd0, '0, 0);
		send_word(1'b1, OPC_STOR_L, 12'hFFF, '0, 0);
		send_word(1'b1, OPC_STOR_R, 12'd0, '0, 0);
		send_word(1'b1, OPC_STOR, 12'd2, '0, 0);
		send_word(1'b1, OPC_LOAD_MQ, 12'd2, '0, 0);
		send_word(1'b1, 8'hFF, 12'd2, '0, 0);

		// random: mostly a small hot set of addresses so loads see written words
		for (int i = 0; i < RandomWords; i++) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
			a = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
			if ($urandom_range(0, 2) == 0)
				send_word(1'b0, 8'($urandom), a, pick_word(), gap);
			else
				send_word(1'b1, pick_opcode(), a, 40'({8'($urandom), $urandom}), gap);
		end
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
